// File: src/cfar2d_pkg.sv
// Shared types, constants and register codes of the 2-D CA-CFAR detector.
package cfar2d_pkg;

    localparam int unsigned DEF_MAX_COLS    = 1024;
    localparam int unsigned DEF_MAX_ROWS    = 1024;
    localparam int unsigned DEF_MAX_WIN     = 15;
    localparam int unsigned DEF_SAMPLE_BITS = 16;

    localparam int unsigned EXT_W      = 13;
    localparam int unsigned FRAME_W    = 11;
    localparam int unsigned WIN_W      = 4;
    localparam int unsigned SCALE_W    = 24;
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned VAL_W      = 16;
    localparam int unsigned SUMO_W     = 24;
    localparam int unsigned TH_W       = 48;
    localparam int unsigned TDATA_W    = 136;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_AW    = 3;
    localparam int unsigned FIFO_CW    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_ROWS   = 3'd0,
        REG_FRAME_COLS   = 3'd1,
        REG_OUTER_ROWS   = 3'd2,
        REG_OUTER_COLS   = 3'd3,
        REG_INNER_ROWS   = 3'd4,
        REG_INNER_COLS   = 3'd5,
        REG_SCALE_FACTOR = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic              config_bad;
        logic              frame_end;
        logic              detected;
        logic [TH_W-1:0]   threshold;
        logic [SUMO_W-1:0] inner_sum;
        logic [SUMO_W-1:0] outer_sum;
        logic [VAL_W-1:0]  cell_value;
        logic [IDX_W-1:0]  cell_col;
        logic [IDX_W-1:0]  cell_row;
    } t_result;

endpackage

// File: src/cfar2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfar2d_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: src/cfar2d_cell.sv
// One line-delay cell: holds one earlier row and passes the row above to its neighbor.
module cfar2d_cell #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] w_ram_q;
    logic             r_fwd;
    logic             n_fwd;
    logic [WIDTH-1:0] r_fwd_data;

    cfar2d_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_ram_q)
    );

    // bypass a write that lands on the address read in the same cycle
    assign n_fwd = i_rd_en && i_wr_en && (i_rd_addr == i_wr_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= n_fwd;
        end
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : w_ram_q;
endmodule

// File: src/cfar_2d_cell_average_detector_core.sv
// Top level of the 2-D cell-averaging CFAR detector.
//
// Samples enter on the s_axis channel in row-major raster order, one word per
// cycle while s_axis_tready is high. A chain of line-delay cells, each one RAM
// row deep, presents a full column of the last MAX_WIN rows; column sums of the
// outer and guard windows are formed over two registered stages, and running
// sums over the columns give the window sums. Threshold and decision take two
// more stages. Throughput: one sample per cycle while s_axis_tready is high. A
// result is registered through each stage and then through the output queue.
// Centres whose outer window leaves the frame produce no word.
// Configuration goes through the cfg write channel, always ready; the user must
// change it only while no sample is in flight, as the block does not enforce it.
// Reset clears position, pipeline valid bits and the output queue; the line
// store is not cleared. If m_axis stalls, results wait in an 8-entry queue and
// s_axis_tready drops once queue plus in-flight samples fill it.
module cfar_2d_cell_average_detector_core
    import cfar2d_pkg::*;
#(
    parameter int unsigned MAX_COLS    = cfar2d_pkg::DEF_MAX_COLS,
    parameter int unsigned MAX_ROWS    = cfar2d_pkg::DEF_MAX_ROWS,
    parameter int unsigned MAX_WIN     = cfar2d_pkg::DEF_MAX_WIN,
    parameter int unsigned SAMPLE_BITS = cfar2d_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cfar2d_pkg::VAL_W-1:0]      s_axis_tdata,   // sample
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // cell_row, cell_col, cell_value, outer_sum, inner_sum, threshold, detected, 0 pad
    output logic [cfar2d_pkg::TDATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast,   // frame_end
    output logic                              m_axis_tuser,   // config_bad
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cfar2d_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cfar2d_pkg::SCALE_W-1:0]    i_cfg_data
);
    localparam int unsigned COL_W = $clog2(MAX_COLS);
    localparam int unsigned ROW_W = $clog2(MAX_ROWS);
    localparam int unsigned MAXH  = (MAX_WIN - 1) / 2;
    localparam int unsigned HW    = $clog2(MAXH + 1);
    localparam int unsigned TW    = $clog2(MAX_WIN);
    localparam int unsigned CS_W  = SAMPLE_BITS + $clog2(MAX_WIN + 1);
    localparam int unsigned SUM_W = CS_W + $clog2(MAX_WIN + 1);
    localparam int unsigned NG    = (MAX_WIN + 3) / 4;

    // configuration registers
    logic [FRAME_W-1:0] r_frame_rows, r_frame_cols;
    logic [WIN_W-1:0]   r_outer_rows, r_outer_cols, r_inner_rows, r_inner_cols;
    logic [SCALE_W-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= FRAME_W'(45);
            r_frame_cols <= FRAME_W'(45);
            r_outer_rows <= WIN_W'(5);
            r_outer_cols <= WIN_W'(3);
            r_inner_rows <= WIN_W'(3);
            r_inner_cols <= WIN_W'(1);
            r_scale      <= SCALE_W'(30660);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_ROWS:   r_frame_rows <= i_cfg_data[FRAME_W-1:0];
                REG_FRAME_COLS:   r_frame_cols <= i_cfg_data[FRAME_W-1:0];
                REG_OUTER_ROWS:   r_outer_rows <= i_cfg_data[WIN_W-1:0];
                REG_OUTER_COLS:   r_outer_cols <= i_cfg_data[WIN_W-1:0];
                REG_INNER_ROWS:   r_inner_rows <= i_cfg_data[WIN_W-1:0];
                REG_INNER_COLS:   r_inner_cols <= i_cfg_data[WIN_W-1:0];
                REG_SCALE_FACTOR: r_scale      <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // derived geometry
    logic [EXT_W-1:0] w_fr, w_fc, w_er, w_ec;
    logic [7:0]       w_hr8, w_hc8, w_ir8, w_ic8;
    logic [HW-1:0]    w_hr, w_hc, w_ir, w_ic;
    logic             w_bad;

    always_comb begin
        w_fr = EXT_W'(r_frame_rows);
        w_fc = EXT_W'(r_frame_cols);
        w_er = (w_fr == '0) ? EXT_W'(1) : ((w_fr > EXT_W'(MAX_ROWS)) ? EXT_W'(MAX_ROWS) : w_fr);
        w_ec = (w_fc == '0) ? EXT_W'(1) : ((w_fc > EXT_W'(MAX_COLS)) ? EXT_W'(MAX_COLS) : w_fc);
        w_hr8 = 8'(r_outer_rows[WIN_W-1:1]);
        w_hc8 = 8'(r_outer_cols[WIN_W-1:1]);
        if (w_hr8 > 8'(MAXH)) w_hr8 = 8'(MAXH);
        if (w_hc8 > 8'(MAXH)) w_hc8 = 8'(MAXH);
        w_ir8 = 8'(r_inner_rows[WIN_W-1:1]);
        w_ic8 = 8'(r_inner_cols[WIN_W-1:1]);
        if (w_ir8 > w_hr8) w_ir8 = w_hr8;
        if (w_ic8 > w_hc8) w_ic8 = w_hc8;
        w_hr = w_hr8[HW-1:0];
        w_hc = w_hc8[HW-1:0];
        w_ir = w_ir8[HW-1:0];
        w_ic = w_ic8[HW-1:0];
        w_bad = (w_fr == '0) || (w_fr > EXT_W'(MAX_ROWS)) ||
                (w_fc == '0) || (w_fc > EXT_W'(MAX_COLS)) ||
                !r_outer_rows[0] || !r_outer_cols[0] ||
                !r_inner_rows[0] || !r_inner_cols[0] ||
                (r_inner_rows >= r_outer_rows) || (r_inner_cols >= r_outer_cols) ||
                (FRAME_W'(r_outer_rows) >= r_frame_rows) ||
                (FRAME_W'(r_outer_cols) >= r_frame_cols) ||
                (8'(r_outer_rows) > 8'(MAX_WIN)) || (8'(r_outer_cols) > 8'(MAX_WIN));
    end

    // input position
    logic             w_accept;
    logic [ROW_W-1:0] r_row, w_r0;
    logic [COL_W-1:0] r_col, w_c0;
    logic             w_wrap, w_emit0, w_last0, w_col_end;
    logic [EXT_W-1:0] w_c1, w_r1;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_wrap    = (EXT_W'(r_row) >= w_er) || (EXT_W'(r_col) >= w_ec);
        w_r0      = w_wrap ? '0 : r_row;
        w_c0      = w_wrap ? '0 : r_col;
        w_c1      = EXT_W'(w_c0) + EXT_W'(1);
        w_r1      = EXT_W'(w_r0) + EXT_W'(1);
        w_col_end = (w_c1 >= w_ec);
        w_emit0   = (EXT_W'(w_r0) >= EXT_W'({w_hr, 1'b0})) &&
                    (EXT_W'(w_c0) >= EXT_W'({w_hc, 1'b0}));
        w_last0   = (w_r1 == w_er) && w_col_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            if (w_col_end) begin
                r_col <= '0;
                r_row <= (w_r1 >= w_er) ? '0 : w_r1[ROW_W-1:0];
            end else begin
                r_col <= w_c1[COL_W-1:0];
            end
        end
    end

    // stage 1: line cells read
    logic                   r_v1, r_e1, r_l1;
    logic [SAMPLE_BITS-1:0] r_s1;
    logic [ROW_W-1:0]       r_r1;
    logic [COL_W-1:0]       r_c1;
    logic [SAMPLE_BITS-1:0] w_vec [MAX_WIN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
        end
        if (w_accept) begin
            r_s1 <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_r1 <= w_r0;
            r_c1 <= w_c0;
            r_e1 <= w_emit0;
            r_l1 <= w_last0;
        end
    end

    assign w_vec[0] = r_s1;

    genvar gk;
    generate
        for (gk = 1; gk < MAX_WIN; gk++) begin : g_cell
            cfar2d_cell #(
                .WIDTH (SAMPLE_BITS),
                .DEPTH (MAX_COLS)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_rd_en   (w_accept),
                .i_rd_addr (w_c0),
                .i_wr_en   (r_v1),
                .i_wr_addr (r_c1),
                .i_wr_data (w_vec[gk-1]),
                .o_rd_data (w_vec[gk])
            );
        end
    endgenerate

    // stage 1 -> 2: masked partial column sums
    logic [CS_W-1:0]        w_po [NG];
    logic [CS_W-1:0]        w_pi [NG];
    logic [CS_W-1:0]        r_po [NG];
    logic [CS_W-1:0]        r_pi [NG];
    logic [SAMPLE_BITS-1:0] r_cv2;
    logic                   r_v2, r_e2, r_l2;
    logic [ROW_W-1:0]       r_r2;
    logic [COL_W-1:0]       r_c2;
    logic [7:0]             w_lo_i, w_hi_i, w_hi_o;

    always_comb begin
        w_hi_o = 8'({w_hr, 1'b0});
        w_lo_i = 8'(w_hr) - 8'(w_ir);
        w_hi_i = 8'(w_hr) + 8'(w_ir);
        for (int g = 0; g < NG; g++) begin
            w_po[g] = '0;
            w_pi[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if (4 * g + j < MAX_WIN) begin
                    if (8'(4 * g + j) <= w_hi_o) begin
                        w_po[g] = w_po[g] + CS_W'(w_vec[4 * g + j]);
                    end
                    if (8'(4 * g + j) >= w_lo_i && 8'(4 * g + j) <= w_hi_i) begin
                        w_pi[g] = w_pi[g] + CS_W'(w_vec[4 * g + j]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_po  <= w_po;
        r_pi  <= w_pi;
        r_cv2 <= w_vec[TW'(w_hr)];
        r_r2  <= r_r1;
        r_c2  <= r_c1;
        r_e2  <= r_e1;
        r_l2  <= r_l1;
    end

    // stage 2 -> 3: column sums
    logic [CS_W-1:0]        w_co, w_ci, r_co3, r_ci3;
    logic [SAMPLE_BITS-1:0] r_cv3;
    logic                   r_v3, r_e3, r_l3;
    logic [ROW_W-1:0]       r_r3;
    logic [COL_W-1:0]       r_c3;

    always_comb begin
        w_co = '0;
        w_ci = '0;
        for (int g = 0; g < NG; g++) begin
            w_co = w_co + r_po[g];
            w_ci = w_ci + r_pi[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_co3 <= w_co;
        r_ci3 <= w_ci;
        r_cv3 <= r_cv2;
        r_r3  <= r_r2;
        r_c3  <= r_c2;
        r_e3  <= r_e2;
        r_l3  <= r_l2;
    end

    // stage 3 -> 4: running sums along the row
    logic [CS_W-1:0]        r_to [MAX_WIN];
    logic [CS_W-1:0]        r_ti [MAX_WIN];
    logic [SAMPLE_BITS-1:0] r_tv [MAX_WIN];
    logic [SUM_W-1:0]       r_os, r_is, n_os, n_is;
    logic [CS_W-1:0]        w_o_leave, w_i_enter, w_i_leave;
    logic [SAMPLE_BITS-1:0] w_val, r_val4;
    logic [HW-1:0]          w_d;
    logic [TW-1:0]          w_idx_ie, w_idx_il, w_idx_ol, w_idx_v;
    logic                   r_v4, r_e4, r_l4;
    logic [ROW_W-1:0]       r_r4;
    logic [COL_W-1:0]       r_c4;

    always_comb begin
        w_d      = w_hc - w_ic;
        w_idx_ol = TW'({w_hc, 1'b0});
        w_idx_il = TW'(w_hc) + TW'(w_ic);
        w_idx_ie = TW'(w_d) - TW'(1);
        w_idx_v  = TW'(w_hc) - TW'(1);
        w_o_leave = (EXT_W'(r_c3) > EXT_W'({w_hc, 1'b0})) ? r_to[w_idx_ol] : '0;
        w_i_leave = (EXT_W'(r_c3) > EXT_W'(w_idx_il)) ? r_ti[w_idx_il] : '0;
        if (EXT_W'(r_c3) < EXT_W'(w_d)) begin
            w_i_enter = '0;
        end else begin
            w_i_enter = (w_d == '0) ? r_ci3 : r_ti[w_idx_ie];
        end
        w_val = (w_hc == '0) ? r_cv3 : r_tv[w_idx_v];
        if (r_c3 == '0) begin
            n_os = SUM_W'(r_co3);
            n_is = SUM_W'(w_i_enter);
        end else begin
            n_os = r_os + SUM_W'(r_co3) - SUM_W'(w_o_leave);
            n_is = r_is + SUM_W'(w_i_enter) - SUM_W'(w_i_leave);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_os <= '0;
            r_is <= '0;
        end else begin
            r_v4 <= r_v3;
            if (r_v3) begin
                r_os <= n_os;
                r_is <= n_is;
            end
        end
        if (r_v3) begin
            r_to[0] <= r_co3;
            r_ti[0] <= r_ci3;
            r_tv[0] <= r_cv3;
            for (int j = 1; j < MAX_WIN; j++) begin
                r_to[j] <= r_to[j-1];
                r_ti[j] <= r_ti[j-1];
                r_tv[j] <= r_tv[j-1];
            end
        end
        r_val4 <= w_val;
        r_r4   <= r_r3;
        r_c4   <= r_c3;
        r_e4   <= r_e3;
        r_l4   <= r_l3;
    end

    // stage 4 -> 5: threshold product
    logic [SUMO_W-1:0]      w_os24, w_is24, w_diff;
    logic [TH_W-1:0]        r_th5;
    logic [SUMO_W-1:0]      r_os5, r_is5;
    logic [SAMPLE_BITS-1:0] r_val5;
    logic                   r_v5, r_e5, r_l5;
    logic [ROW_W-1:0]       r_r5;
    logic [COL_W-1:0]       r_c5;

    assign w_os24 = SUMO_W'(r_os);
    assign w_is24 = SUMO_W'(r_is);
    assign w_diff = SUMO_W'(r_os - r_is);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_th5  <= TH_W'(w_diff) * TH_W'(r_scale);
        r_os5  <= w_os24;
        r_is5  <= w_is24;
        r_val5 <= r_val4;
        r_r5   <= r_r4;
        r_c5   <= r_c4;
        r_e5   <= r_e4;
        r_l5   <= r_l4;
    end

    // stage 5: decision and output queue
    t_result                w_res;
    logic [TH_W-1:0]        w_vsh;
    logic [ROW_W-1:0]       w_cr;
    logic [COL_W-1:0]       w_cc;
    t_result                r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wp, r_rp;
    logic [FIFO_CW-1:0]     r_cnt;
    logic                   w_push, w_pop;
    logic [FIFO_CW:0]       w_used;

    always_comb begin
        w_vsh = TH_W'(r_val5) << 16;
        w_cr  = r_r5 - ROW_W'(w_hr);
        w_cc  = r_c5 - COL_W'(w_hc);
        w_res.cell_row   = IDX_W'(w_cr);
        w_res.cell_col   = IDX_W'(w_cc);
        w_res.cell_value = VAL_W'(r_val5);
        w_res.outer_sum  = r_os5;
        w_res.inner_sum  = r_is5;
        w_res.threshold  = r_th5;
        w_res.detected   = !w_bad && (w_vsh > r_th5);
        w_res.frame_end  = r_l5;
        w_res.config_bad = w_bad;
    end

    assign w_push = r_v5 && r_e5;
    assign w_pop  = m_axis_tvalid && m_axis_tready;
    assign w_used = (FIFO_CW+1)'(r_cnt) + (FIFO_CW+1)'(r_v1) + (FIFO_CW+1)'(r_v2) +
                    (FIFO_CW+1)'(r_v3) + (FIFO_CW+1)'(r_v4) + (FIFO_CW+1)'(r_v5);
    assign s_axis_tready = (w_used < (FIFO_CW+1)'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + FIFO_CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - FIFO_CW'(1);
            end
        end
        if (w_push) begin
            r_fifo[r_wp] <= w_res;
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {3'b000, r_fifo[r_rp].detected, r_fifo[r_rp].threshold,
                            r_fifo[r_rp].inner_sum, r_fifo[r_rp].outer_sum,
                            r_fifo[r_rp].cell_value, r_fifo[r_rp].cell_col,
                            r_fifo[r_rp].cell_row};
    assign m_axis_tlast  = r_fifo[r_rp].frame_end;
    assign m_axis_tuser  = r_fifo[r_rp].config_bad;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |-> r_cnt < FIFO_CW'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= (FIFO_CW+1)'(FIFO_DEPTH))
        else $error("queue plus in-flight samples exceed queue depth");

    a_tready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == FIFO_CW'(FIFO_DEPTH) |-> !s_axis_tready)
        else $error("input taken with full queue");
endmodule

// File: tb/tb_cfar_2d_cell_average_detector_core.sv
// Self-checking testbench of the 2-D cell-averaging CFAR detector core.
module tb_cfar_2d_cell_average_detector_core;
    import cfar2d_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 1_500_000;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int {FILL_ZERO, FILL_MAX, FILL_RAND, FILL_PEAK} t_fill;

    typedef struct {
        int    rows;
        int    cols;
        int    orow;
        int    ocol;
        int    irow;
        int    icol;
        int    scale;
        t_fill fill;
        int    bad;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [VAL_W-1:0]     s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SCALE_W-1:0]   i_cfg_data;

    cfar_2d_cell_average_detector_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    logic [FRAME_W-1:0] p_rows, p_cols;
    logic [WIN_W-1:0]   p_orow, p_ocol, p_irow, p_icol;
    logic [SCALE_W-1:0] p_scale;
    logic [VAL_W-1:0]   line_mem [0:DEF_MAX_WIN*DEF_MAX_COLS-1];
    int                 pos_row, pos_col;

    t_result expected_words[$];
    int      fails;
    int      words_seen;
    int      items_sent;
    int      want_bad;
    int      cycles;
    logic    calm;

    t_dir_row dir_table[6] = '{
        '{4, 4, 3, 3, 1, 1, 0,        FILL_ZERO, 0},
        '{4, 4, 3, 3, 1, 1, 'h010000, FILL_PEAK, 0},
        '{4, 4, 3, 3, 1, 1, 'hFFFFFF, FILL_MAX,  0},
        '{2, 2, 1, 1, 1, 1, 0,        FILL_RAND, 1},
        '{3, 3, 2, 3, 1, 1, 'h004000, FILL_RAND, 1},
        '{0, 1, 1, 1, 1, 1, 0,        FILL_MAX,  1}
    };

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic logic [SUMO_W-1:0] window_total(int cr, int cc, int hr, int hc);
        int acc;
        acc = 0;
        for (int r = cr - hr; r <= cr + hr; r++)
            for (int c = cc - hc; c <= cc + hc; c++)
                acc += line_mem[(r % DEF_MAX_WIN) * DEF_MAX_COLS + c];
        return acc[SUMO_W-1:0];
    endfunction

    task automatic cfar_predict(input logic [VAL_W-1:0] smp);
        int                 er, ec, hr, hc, ir, ic, r, c, cr, cc;
        bit                 bad;
        logic [SUMO_W-1:0]  diff;
        t_result            e;
        er = p_rows;
        ec = p_cols;
        bad = 0;
        if (er == 0) begin er = 1; bad = 1; end
        if (er > DEF_MAX_ROWS) begin er = DEF_MAX_ROWS; bad = 1; end
        if (ec == 0) begin ec = 1; bad = 1; end
        if (ec > DEF_MAX_COLS) begin ec = DEF_MAX_COLS; bad = 1; end
        if (!p_orow[0] || !p_ocol[0] || !p_irow[0] || !p_icol[0])
            bad = 1;
        if (p_irow >= p_orow || p_icol >= p_ocol)
            bad = 1;
        if (p_orow >= p_rows || p_ocol >= p_cols)
            bad = 1;
        if (p_orow > DEF_MAX_WIN || p_ocol > DEF_MAX_WIN)
            bad = 1;
        hr = p_orow / 2;
        hc = p_ocol / 2;
        ir = p_irow / 2;
        ic = p_icol / 2;
        if (hr > (DEF_MAX_WIN - 1) / 2) hr = (DEF_MAX_WIN - 1) / 2;
        if (hc > (DEF_MAX_WIN - 1) / 2) hc = (DEF_MAX_WIN - 1) / 2;
        if (ir > hr) ir = hr;
        if (ic > hc) ic = hc;
        if (pos_row >= er || pos_col >= ec) begin
            pos_row = 0;
            pos_col = 0;
        end
        r = pos_row;
        c = pos_col;
        line_mem[(r % DEF_MAX_WIN) * DEF_MAX_COLS + c] = smp;
        if (r >= 2 * hr && c >= 2 * hc) begin
            cr = r - hr;
            cc = c - hc;
            e.cell_row   = cr[IDX_W-1:0];
            e.cell_col   = cc[IDX_W-1:0];
            e.cell_value = line_mem[(cr % DEF_MAX_WIN) * DEF_MAX_COLS + cc];
            e.outer_sum  = window_total(cr, cc, hr, hc);
            e.inner_sum  = window_total(cr, cc, ir, ic);
            diff         = e.outer_sum - e.inner_sum;
            e.threshold  = {24'd0, diff} * {24'd0, p_scale};
            e.detected   = !bad && ({16'd0, e.cell_value, 16'd0} > e.threshold);
            e.frame_end  = (r == er - 1) && (c == ec - 1);
            e.config_bad = bad;
            expected_words.push_back(e);
        end
        pos_col = c + 1;
        if (pos_col >= ec) begin
            pos_col = 0;
            pos_row = r + 1;
            if (pos_row >= er)
                pos_row = 0;
        end
    endtask

    task automatic send_sample(input logic [VAL_W-1:0] smp);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 21) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = smp;
        do @(posedge i_clk); while (!s_axis_tready);
        cfar_predict(smp);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        i_cfg_valid   = 1'b1;
        i_cfg_index   = idx;
        i_cfg_data    = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FRAME_ROWS:   p_rows  = val[FRAME_W-1:0];
            REG_FRAME_COLS:   p_cols  = val[FRAME_W-1:0];
            REG_OUTER_ROWS:   p_orow  = val[WIN_W-1:0];
            REG_OUTER_COLS:   p_ocol  = val[WIN_W-1:0];
            REG_INNER_ROWS:   p_irow  = val[WIN_W-1:0];
            REG_INNER_COLS:   p_icol  = val[WIN_W-1:0];
            REG_SCALE_FACTOR: p_scale = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(input int rows, cols, orow, ocol, irow, icol, scale);
        write_reg(REG_FRAME_ROWS, SCALE_W'(rows));
        write_reg(REG_FRAME_COLS, SCALE_W'(cols));
        write_reg(REG_OUTER_ROWS, SCALE_W'(orow));
        write_reg(REG_OUTER_COLS, SCALE_W'(ocol));
        write_reg(REG_INNER_ROWS, SCALE_W'(irow));
        write_reg(REG_INNER_COLS, SCALE_W'(icol));
        write_reg(REG_SCALE_FACTOR, SCALE_W'(scale));
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, SCALE_W'($urandom()));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int frame_cells();
        int er, ec;
        er = (p_rows == 0) ? 1 : (p_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : p_rows;
        ec = (p_cols == 0) ? 1 : (p_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : p_cols;
        return er * ec;
    endfunction

    function automatic int pick_odd_below(int lim);
        if (lim < 1)
            return 1;
        return 2 * $urandom_range((lim - 1) / 2) + 1;
    endfunction

    // keep the receiver random, or always ready while calm
    always @(negedge i_clk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
    end

    always @(posedge i_clk) begin
        t_result e;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("cfar_2d_cell_average_detector_core: mismatch");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_seen++;
            if (expected_words.size() == 0) begin
                $error("unexpected word: tdata %h", m_axis_tdata);
                fails++;
            end else begin
                e = expected_words.pop_front();
                if (m_axis_tdata[9:0] !== e.cell_row) begin
                    $error("cell_row exp %0d got %0d", e.cell_row, m_axis_tdata[9:0]);
                    fails++;
                end
                if (m_axis_tdata[19:10] !== e.cell_col) begin
                    $error("cell_col exp %0d got %0d", e.cell_col, m_axis_tdata[19:10]);
                    fails++;
                end
                if (m_axis_tdata[35:20] !== e.cell_value) begin
                    $error("cell_value exp %0d got %0d", e.cell_value, m_axis_tdata[35:20]);
                    fails++;
                end
                if (m_axis_tdata[59:36] !== e.outer_sum) begin
                    $error("outer_sum exp %0d got %0d", e.outer_sum, m_axis_tdata[59:36]);
                    fails++;
                end
                if (m_axis_tdata[83:60] !== e.inner_sum) begin
                    $error("inner_sum exp %0d got %0d", e.inner_sum, m_axis_tdata[83:60]);
                    fails++;
                end
                if (m_axis_tdata[131:84] !== e.threshold) begin
                    $error("threshold exp %0d got %0d", e.threshold, m_axis_tdata[131:84]);
                    fails++;
                end
                if (m_axis_tdata[132] !== e.detected) begin
                    $error("detected exp %0d got %0d", e.detected, m_axis_tdata[132]);
                    fails++;
                end
                if (m_axis_tdata[135:133] !== 3'd0) begin
                    $error("pad exp 0 got %0d", m_axis_tdata[135:133]);
                    fails++;
                end
                if (m_axis_tlast !== e.frame_end) begin
                    $error("frame_end exp %0d got %0d", e.frame_end, m_axis_tlast);
                    fails++;
                end
                if (m_axis_tuser !== e.config_bad) begin
                    $error("config_bad exp %0d got %0d", e.config_bad, m_axis_tuser);
                    fails++;
                end
                if (want_bad >= 0 && m_axis_tuser !== want_bad[0]) begin
                    $error("config_bad exp %0d got %0d", want_bad, m_axis_tuser);
                    fails++;
                end
            end
        end
    end

    initial begin
        int rows, cols, orow, ocol, irow, icol, scale, frames, n, big_left, phase;
        logic [VAL_W-1:0] v;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_FRAME_ROWS;
        i_cfg_data    = '0;
        calm          = 1'b0;
        fails         = 0;
        words_seen    = 0;
        items_sent    = 0;
        want_bad      = -1;
        cycles        = 0;
        pos_row       = 0;
        pos_col       = 0;
        p_rows = 45; p_cols = 45; p_orow = 5; p_ocol = 3;
        p_irow = 3;  p_icol = 1;  p_scale = 30660;
        for (int k = 0; k < DEF_MAX_WIN * DEF_MAX_COLS; k++)
            line_mem[k] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_table[k]) begin
            write_all(dir_table[k].rows, dir_table[k].cols, dir_table[k].orow,
                      dir_table[k].ocol, dir_table[k].irow, dir_table[k].icol,
                      dir_table[k].scale);
            want_bad = dir_table[k].bad;
            n = frame_cells();
            for (int i = 0; i < n; i++) begin
                case (dir_table[k].fill)
                    FILL_ZERO: v = '0;
                    FILL_MAX:  v = '1;
                    FILL_PEAK: v = (i == n / 2) ? '1 : '0;
                    default:   v = VAL_W'($urandom());
                endcase
                send_sample(v);
            end
            drain_results();
            want_bad = -1;
        end

        big_left = 4;
        phase = 0;
        while (items_sent < 1000) begin
            phase++;
            calm = (phase == 2) || ($urandom_range(5) == 0);
            if (big_left > 0 && $urandom_range(9) == 0) begin
                big_left--;
                case ($urandom_range(3))
                    0: begin rows = 64; cols = $urandom_range(1, 2); end
                    1: begin rows = $urandom_range(1, 2); cols = 64; end
                    2: begin rows = 16; cols = 16; end
                    default: begin rows = 40; cols = 3; end
                endcase
                orow = pick_odd_below(rows > 15 ? 15 : rows);
                ocol = pick_odd_below(cols > 15 ? 15 : cols);
                irow = 1;
                icol = 1;
            end else begin
                rows = $urandom_range(1, 20);
                cols = $urandom_range(1, 20);
                if ($urandom_range(9) < 7) begin
                    orow = pick_odd_below(rows - 1 > 15 ? 15 : rows - 1);
                    ocol = pick_odd_below(cols - 1 > 15 ? 15 : cols - 1);
                    irow = pick_odd_below(orow - 2);
                    icol = pick_odd_below(ocol - 2);
                end else begin
                    if ($urandom_range(5) == 0) rows = 0;
                    if ($urandom_range(5) == 0) cols = 0;
                    orow = $urandom_range(15);
                    ocol = $urandom_range(15);
                    irow = $urandom_range(15);
                    icol = $urandom_range(15);
                end
            end
            scale = ($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF)
                                             : $urandom_range(20000);
            write_all(rows, cols, orow, ocol, irow, icol, scale);
            frames = $urandom_range(1, 3);
            n = frame_cells();
            if (n > 200)
                frames = 1;
            for (int f = 0; f < frames; f++)
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(299) == 0)
                        drain_results();
                    case ($urandom_range(7))
                        0:       v = VAL_W'($urandom_range(15));
                        1:       v = '1;
                        default: v = VAL_W'($urandom());
                    endcase
                    send_sample(v);
                end
            drain_results();
        end

        drain_results();
        if (fails == 0)
            $display("cfar_2d_cell_average_detector_core: match");
        else
            $display("cfar_2d_cell_average_detector_core: mismatch");
        $finish;
    end

endmodule

// File: cfar_2d_cell_average_detector_core.f
src/cfar2d_pkg.sv
src/cfar2d_ram.sv
src/cfar2d_cell.sv
src/cfar_2d_cell_average_detector_core.sv
tb/tb_cfar_2d_cell_average_detector_core.sv
